@@ rtl/irc_tok_pkg.sv @@
// irc_tok_pkg: shared types and constants for the irc line tokenizer
// transfer payload structs, character codes, field kinds and status codes
// no dependencies
`default_nettype none

package irc_tok_pkg;

    localparam int PREFIX_LEN_DEF  = 64;
    localparam int COMMAND_LEN_DEF = 32;
    localparam int PARAM_LEN_DEF   = 64;
    localparam int TRAIL_LEN_DEF   = 512;
    localparam int MAX_PARAMS_DEF  = 16;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_PREFIX  = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_PARAM   = 2'd2;
    localparam logic [1:0] KIND_TRAIL   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0] field_kind;
        logic [3:0] param_index;
        logic [8:0] char_position;
        logic [7:0] char_out;
        logic       char_valid;
        logic       line_done;
        logic [4:0] param_total;
        logic [1:0] parse_status;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/irc_line_tokenizer_unit.sv @@
// irc_line_tokenizer_unit: splits an irc line into prefix, command, params, trailing
// depends on irc_tok_pkg for payload structs and codes
`default_nettype none

//  channel | ports                    | payload
//  --------+--------------------------+------------------------------------
//  input   | s_valid s_ready s_data   | irc_tok_pkg::in_item_t, one byte
//  result  | m_valid m_ready m_data   | irc_tok_pkg::out_item_t, one result
//
//  one result per byte, held in the result register until taken
//  a byte is taken every cycle while the result register is empty or drained
//  parse state advances only on an input transfer; line end returns it to start
//  aresetn (synchronous) clears parse state and the result valid
//  a stalled result holds and blocks input only while m_ready is low

module irc_line_tokenizer_unit #(
    parameter int PREFIX_LEN  = irc_tok_pkg::PREFIX_LEN_DEF,
    parameter int COMMAND_LEN = irc_tok_pkg::COMMAND_LEN_DEF,
    parameter int PARAM_LEN   = irc_tok_pkg::PARAM_LEN_DEF,
    parameter int TRAIL_LEN   = irc_tok_pkg::TRAIL_LEN_DEF,
    parameter int MAX_PARAMS  = irc_tok_pkg::MAX_PARAMS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  irc_tok_pkg::in_item_t   s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output irc_tok_pkg::out_item_t  m_data
);

    localparam logic [2:0] PH_START        = 3'd0;
    localparam logic [2:0] PH_PREFIX       = 3'd1;
    localparam logic [2:0] PH_AFTER_PREFIX = 3'd2;
    localparam logic [2:0] PH_CMD          = 3'd3;
    localparam logic [2:0] PH_AFTER_CMD    = 3'd4;
    localparam logic [2:0] PH_PARAM        = 3'd5;
    localparam logic [2:0] PH_AFTER_PARAM  = 3'd6;
    localparam logic [2:0] PH_TRAIL        = 3'd7;

    localparam logic [9:0] PREFIX_LIM  = 10'(PREFIX_LEN - 1);
    localparam logic [9:0] COMMAND_LIM = 10'(COMMAND_LEN - 1);
    localparam logic [9:0] PARAM_LIM   = 10'(PARAM_LEN - 1);
    localparam logic [9:0] TRAIL_LIM   = 10'(TRAIL_LEN - 1);
    localparam logic [4:0] MAX_CNT     = 5'(MAX_PARAMS);

    logic [2:0] phase_reg, phase_next;
    logic [8:0] field_pos_reg, field_pos_next;
    logic [4:0] param_count_reg, param_count_next;
    logic       overflow_reg, overflow_next;

    logic                   m_valid_reg;
    irc_tok_pkg::out_item_t m_data_reg, m_data_next;

    logic       s_xfer;
    logic       is_colon, is_space;
    logic [8:0] base_pos;
    logic       want_keep;
    logic [1:0] keep_kind;
    logic [3:0] keep_idx;
    logic [9:0] keep_lim;
    logic [2:0] phase_step;
    logic [4:0] count_step;
    logic       ovf_step;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign is_colon = (s_data.line_byte == irc_tok_pkg::CH_COLON);
    assign is_space = (s_data.line_byte == irc_tok_pkg::CH_SPACE);

    always_comb begin
        phase_step = phase_reg;
        base_pos   = field_pos_reg;
        count_step = param_count_reg;
        ovf_step   = overflow_reg;
        want_keep  = 1'b0;
        keep_kind  = irc_tok_pkg::KIND_PREFIX;
        keep_idx   = 4'd0;

        unique case (phase_reg)
            PH_START: begin
                base_pos = '0;
                if (is_colon) begin
                    phase_step = PH_PREFIX;
                end else if (is_space) begin
                    phase_step = PH_AFTER_CMD;
                end else begin
                    phase_step = PH_CMD;
                    want_keep  = 1'b1;
                    keep_kind  = irc_tok_pkg::KIND_COMMAND;
                end
            end
            PH_PREFIX: begin
                if (is_space) begin
                    phase_step = PH_AFTER_PREFIX;
                end else begin
                    want_keep = 1'b1;
                    keep_kind = irc_tok_pkg::KIND_PREFIX;
                end
            end
            PH_AFTER_PREFIX: begin
                if (!is_space) begin
                    base_pos   = '0;
                    phase_step = PH_CMD;
                    want_keep  = 1'b1;
                    keep_kind  = irc_tok_pkg::KIND_COMMAND;
                end
            end
            PH_CMD: begin
                if (is_space) begin
                    phase_step = PH_AFTER_CMD;
                end else begin
                    want_keep = 1'b1;
                    keep_kind = irc_tok_pkg::KIND_COMMAND;
                end
            end
            PH_AFTER_CMD, PH_AFTER_PARAM: begin
                if (is_colon) begin
                    base_pos   = '0;
                    phase_step = PH_TRAIL;
                end else if (!is_space) begin
                    base_pos   = '0;
                    phase_step = PH_PARAM;
                    if (param_count_reg >= MAX_CNT) begin
                        ovf_step = 1'b1;
                    end else begin
                        want_keep = 1'b1;
                        keep_kind = irc_tok_pkg::KIND_PARAM;
                        keep_idx  = param_count_reg[3:0];
                    end
                end
            end
            PH_PARAM: begin
                if (is_space) begin
                    if (param_count_reg < MAX_CNT) begin
                        count_step = param_count_reg + 5'd1;
                    end
                    phase_step = PH_AFTER_PARAM;
                end else if (param_count_reg < MAX_CNT) begin
                    want_keep = 1'b1;
                    keep_kind = irc_tok_pkg::KIND_PARAM;
                    keep_idx  = param_count_reg[3:0];
                end
            end
            default: begin
                want_keep = 1'b1;
                keep_kind = irc_tok_pkg::KIND_TRAIL;
            end
        endcase
    end

    always_comb begin
        unique case (keep_kind)
            irc_tok_pkg::KIND_PREFIX:  keep_lim = PREFIX_LIM;
            irc_tok_pkg::KIND_COMMAND: keep_lim = COMMAND_LIM;
            irc_tok_pkg::KIND_PARAM:   keep_lim = PARAM_LIM;
            default:                   keep_lim = TRAIL_LIM;
        endcase
    end

    always_comb begin
        m_data_next      = '0;
        phase_next       = phase_step;
        field_pos_next   = base_pos;
        param_count_next = count_step;
        overflow_next    = ovf_step;

        if (want_keep && ({1'b0, base_pos} < keep_lim)) begin
            m_data_next.field_kind    = keep_kind;
            m_data_next.param_index   = keep_idx;
            m_data_next.char_position = base_pos;
            m_data_next.char_out      = s_data.line_byte;
            m_data_next.char_valid    = 1'b1;
            field_pos_next            = base_pos + 9'd1;
        end

        if (s_data.end_of_line) begin
            m_data_next.line_done = 1'b1;
            if (phase_step == PH_PREFIX || phase_step == PH_AFTER_PREFIX ||
                phase_step == PH_CMD || phase_step == PH_START) begin
                m_data_next.parse_status = irc_tok_pkg::STAT_NO_SPACE;
            end else begin
                m_data_next.param_total = count_step;
                if (phase_step == PH_AFTER_CMD || phase_step == PH_PARAM) begin
                    if (count_step < MAX_CNT) begin
                        m_data_next.param_total = count_step + 5'd1;
                    end else if (phase_step == PH_AFTER_CMD) begin
                        overflow_next = 1'b1;
                    end
                end
                m_data_next.parse_status = overflow_next ? irc_tok_pkg::STAT_OVERFLOW
                                                         : irc_tok_pkg::STAT_OK;
            end
            phase_next       = PH_START;
            field_pos_next   = '0;
            param_count_next = '0;
            overflow_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_START;
            field_pos_reg   <= '0;
            param_count_reg <= '0;
            overflow_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_xfer) begin
                phase_reg       <= phase_next;
                field_pos_reg   <= field_pos_next;
                param_count_reg <= param_count_next;
                overflow_reg    <= overflow_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

    // parse state is back at line start after a line end transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_data.end_of_line |=> phase_reg == PH_START && param_count_reg == 5'd0
            && !overflow_reg)
        else $error("state not cleared after line end");

    // a dropped byte carries no tags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.char_valid |-> m_data.field_kind == irc_tok_pkg::KIND_PREFIX
            && m_data.char_out == 8'd0 && m_data.char_position == 9'd0)
        else $error("dropped byte has nonzero tags");

    // count and status appear only on the line end result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.line_done |-> m_data.param_total == 5'd0
            && m_data.parse_status == irc_tok_pkg::STAT_OK)
        else $error("count or status outside line end");

    // parameter count never passes its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        param_count_reg <= MAX_CNT && (!m_valid || m_data.param_total <= MAX_CNT))
        else $error("parameter count over limit");

    // a parameter byte never comes from a dropped parameter
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.char_valid && m_data.field_kind == irc_tok_pkg::KIND_PARAM
            |-> {1'b0, m_data.param_index} < MAX_CNT)
        else $error("parameter byte beyond limit");

endmodule

`default_nettype wire

@@ tb/irc_line_tokenizer_unit_tb.sv @@
`timescale 1ns / 1ps
// irc_line_tokenizer_unit_tb: self-checking bench for the irc line tokenizer
// streams byte transfers of irc lines, predicts each tagged result and compares it field by field
// depends on irc_tok_pkg and irc_line_tokenizer_unit

module irc_line_tokenizer_unit_tb;

    localparam logic [2:0] PH_START        = 3'd0;
    localparam logic [2:0] PH_PREFIX       = 3'd1;
    localparam logic [2:0] PH_AFTER_PREFIX = 3'd2;
    localparam logic [2:0] PH_CMD          = 3'd3;
    localparam logic [2:0] PH_AFTER_CMD    = 3'd4;
    localparam logic [2:0] PH_PARAM        = 3'd5;
    localparam logic [2:0] PH_AFTER_PARAM  = 3'd6;
    localparam logic [2:0] PH_TRAIL        = 3'd7;

    localparam logic [4:0] MAX_CNT = 5'(irc_tok_pkg::MAX_PARAMS_DEF);

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    irc_tok_pkg::in_item_t  s_data  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    irc_tok_pkg::out_item_t m_data;

    irc_line_tokenizer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    irc_tok_pkg::in_item_t  line_bytes[$];
    irc_tok_pkg::out_item_t tagged_bytes_due[$];
    logic [7:0]             line_buf[$];

    logic [2:0]             phase         = PH_START;
    logic [8:0]             field_pos     = '0;
    logic [4:0]             param_count   = '0;
    logic                   overflow_flag = 1'b0;
    irc_tok_pkg::out_item_t pred;

    int errors      = 0;
    int lines_built = 0;
    int lines_seen  = 0;
    int kept_seen   = 0;
    int results     = 0;
    int status_seen [0:2] = '{0, 0, 0};
    int calm_left [0:1]   = '{0, 0};
    int send_gap   = 0;
    int stall_left = 0;
    bit sent       = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function void keep_byte(logic [1:0] kind, logic [3:0] idx, int limit, logic [7:0] b);
        if (int'(field_pos) < limit - 1) begin
            pred.field_kind    = kind;
            pred.param_index   = idx;
            pred.char_position = field_pos;
            pred.char_out      = b;
            pred.char_valid    = 1'b1;
            field_pos          = field_pos + 9'd1;
        end
    endfunction

    function irc_tok_pkg::out_item_t tokenize_byte(irc_tok_pkg::in_item_t it);
        logic [7:0] b;
        b    = it.line_byte;
        pred = '0;
        case (phase)
            PH_START: begin
                field_pos = '0;
                if (b == irc_tok_pkg::CH_COLON) begin
                    phase = PH_PREFIX;
                end else if (b == irc_tok_pkg::CH_SPACE) begin
                    phase = PH_AFTER_CMD;
                end else begin
                    phase = PH_CMD;
                    keep_byte(irc_tok_pkg::KIND_COMMAND, 4'd0,
                              irc_tok_pkg::COMMAND_LEN_DEF, b);
                end
            end
            PH_PREFIX: begin
                if (b == irc_tok_pkg::CH_SPACE) phase = PH_AFTER_PREFIX;
                else keep_byte(irc_tok_pkg::KIND_PREFIX, 4'd0, irc_tok_pkg::PREFIX_LEN_DEF, b);
            end
            PH_AFTER_PREFIX: begin
                if (b != irc_tok_pkg::CH_SPACE) begin
                    field_pos = '0;
                    phase     = PH_CMD;
                    keep_byte(irc_tok_pkg::KIND_COMMAND, 4'd0,
                              irc_tok_pkg::COMMAND_LEN_DEF, b);
                end
            end
            PH_CMD: begin
                if (b == irc_tok_pkg::CH_SPACE) phase = PH_AFTER_CMD;
                else keep_byte(irc_tok_pkg::KIND_COMMAND, 4'd0,
                               irc_tok_pkg::COMMAND_LEN_DEF, b);
            end
            PH_AFTER_CMD, PH_AFTER_PARAM: begin
                if (b == irc_tok_pkg::CH_COLON) begin
                    field_pos = '0;
                    phase     = PH_TRAIL;
                end else if (b != irc_tok_pkg::CH_SPACE) begin
                    field_pos = '0;
                    phase     = PH_PARAM;
                    if (param_count >= MAX_CNT) overflow_flag = 1'b1;
                    else keep_byte(irc_tok_pkg::KIND_PARAM, param_count[3:0],
                                   irc_tok_pkg::PARAM_LEN_DEF, b);
                end
            end
            PH_PARAM: begin
                if (b == irc_tok_pkg::CH_SPACE) begin
                    if (param_count < MAX_CNT) param_count = param_count + 5'd1;
                    phase = PH_AFTER_PARAM;
                end else if (param_count < MAX_CNT) begin
                    keep_byte(irc_tok_pkg::KIND_PARAM, param_count[3:0],
                              irc_tok_pkg::PARAM_LEN_DEF, b);
                end
            end
            default: begin
                keep_byte(irc_tok_pkg::KIND_TRAIL, 4'd0, irc_tok_pkg::TRAIL_LEN_DEF, b);
            end
        endcase
        if (it.end_of_line) begin
            pred.line_done = 1'b1;
            if (phase == PH_PREFIX || phase == PH_AFTER_PREFIX ||
                phase == PH_CMD || phase == PH_START) begin
                pred.parse_status = irc_tok_pkg::STAT_NO_SPACE;
                pred.param_total  = '0;
            end else begin
                pred.param_total = param_count;
                if (phase == PH_AFTER_CMD || phase == PH_PARAM) begin
                    if (param_count < MAX_CNT) pred.param_total = param_count + 5'd1;
                    else if (phase == PH_AFTER_CMD) overflow_flag = 1'b1;
                end
                pred.parse_status = overflow_flag ? irc_tok_pkg::STAT_OVERFLOW
                                                  : irc_tok_pkg::STAT_OK;
            end
            phase         = PH_START;
            field_pos     = '0;
            param_count   = '0;
            overflow_flag = 1'b0;
        end
        return pred;
    endfunction

    // side 0 is the byte sender, side 1 the result receiver
    function int pick_gap(int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0) calm_left[side] = $urandom_range(40, 160);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0) begin
            c = 8'($urandom_range(33, 126));
        end else begin
            c = 8'($urandom_range(0, 255));
            if (c == irc_tok_pkg::CH_SPACE) c = 8'h7E;
        end
        return c;
    endfunction

    function int pick_len(int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, 8);
        if (r < 96) return $urandom_range(limit - 3, limit + 3);
        return $urandom_range(1, limit);
    endfunction

    task add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task add_spaces();
        repeat ($urandom_range(1, 3)) line_buf.push_back(irc_tok_pkg::CH_SPACE);
    endtask

    task add_field(int len, bit lead_no_colon);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = field_char();
            if (i == 0 && lead_no_colon && c == irc_tok_pkg::CH_COLON) c = 8'h41;
            line_buf.push_back(c);
        end
    endtask

    task emit_line();
        irc_tok_pkg::in_item_t it;
        while (line_buf.size() > 0) begin
            it.line_byte   = line_buf.pop_front();
            it.end_of_line = (line_buf.size() == 0);
            line_bytes.push_back(it);
        end
        lines_built++;
    endtask

    task gen_random_line();
        int n;
        int keep;
        if ($urandom_range(0, 99) < 12) begin
            // noise built from separators, colons and random bytes
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: line_buf.push_back(irc_tok_pkg::CH_SPACE);
                    1: line_buf.push_back(irc_tok_pkg::CH_COLON);
                    default: line_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                line_buf.push_back(irc_tok_pkg::CH_COLON);
                add_field(pick_len(irc_tok_pkg::PREFIX_LEN_DEF), 1'b0);
                add_spaces();
            end
            if ($urandom_range(0, 19) == 0) add_spaces();
            else add_field(pick_len(irc_tok_pkg::COMMAND_LEN_DEF), 1'b1);
            n = $urandom_range(0, 9);
            if (n < 7) n = $urandom_range(0, 4);
            else if (n < 9) n = $urandom_range(5, 15);
            else n = $urandom_range(16, 20);
            repeat (n) begin
                add_spaces();
                add_field(pick_len(irc_tok_pkg::PARAM_LEN_DEF), 1'b1);
            end
            if ($urandom_range(0, 1) == 1) begin
                add_spaces();
                line_buf.push_back(irc_tok_pkg::CH_COLON);
                if (lines_built == 30 || $urandom_range(0, 79) == 0) n = $urandom_range(500, 530);
                else n = $urandom_range(0, 20);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
                    else line_buf.push_back(8'($urandom_range(32, 126)));
                end
            end else if ($urandom_range(0, 9) == 0) begin
                add_spaces();
            end
            if (line_buf.size() > 1 && $urandom_range(0, 99) < 8) begin
                keep = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > keep) line_buf.delete(line_buf.size() - 1);
            end
        end
        emit_line();
    endtask

    task check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // byte driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || sent) begin
                sent = 1'b0;
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap--;
                end else if (line_bytes.size() > 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= line_bytes.pop_front();
                    send_gap = pick_gap(0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall_left = pick_gap(1);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tagged_bytes_due.push_back(tokenize_byte(s_data));
            sent = 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        irc_tok_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tagged_bytes_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, m_data);
            end else begin
                want = tagged_bytes_due.pop_front();
                check_field("field_kind", int'(want.field_kind), int'(m_data.field_kind));
                check_field("param_index", int'(want.param_index), int'(m_data.param_index));
                check_field("char_position", int'(want.char_position),
                            int'(m_data.char_position));
                check_field("char_out", int'(want.char_out), int'(m_data.char_out));
                check_field("char_valid", int'(want.char_valid), int'(m_data.char_valid));
                check_field("line_done", int'(want.line_done), int'(m_data.line_done));
                check_field("param_total", int'(want.param_total), int'(m_data.param_total));
                check_field("parse_status", int'(want.parse_status),
                            int'(m_data.parse_status));
                results++;
                if (want.char_valid) kept_seen++;
                if (want.line_done) begin
                    lines_seen++;
                    status_seen[want.parse_status]++;
                end
            end
        end
    end

    initial begin
        // command only, empty prefix, prefix without command
        add_text("A");
        emit_line();
        add_text(":");
        emit_line();
        add_text(":p ");
        emit_line();
        // leading space, line ending after command spaces, spaces after last param
        add_text(" ");
        emit_line();
        add_text("C ");
        emit_line();
        add_text("C p ");
        emit_line();
        // trailing text keeps its spaces
        add_text("C :t x");
        emit_line();
        // extreme byte values in command and parameter
        line_buf.push_back(8'h00);
        line_buf.push_back(irc_tok_pkg::CH_SPACE);
        line_buf.push_back(8'hFF);
        emit_line();
        while (line_bytes.size() < 1700) gen_random_line();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (line_bytes.size() > 0 || s_valid || tagged_bytes_due.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("run covered %0d lines, %0d results, %0d kept field bytes",
                 lines_seen, results, kept_seen);
        $display("line status: ok %0d, missing space %0d, too many params %0d",
                 status_seen[irc_tok_pkg::STAT_OK],
                 status_seen[irc_tok_pkg::STAT_NO_SPACE],
                 status_seen[irc_tok_pkg::STAT_OVERFLOW]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t timeout with %0d results outstanding", $time, tagged_bytes_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
